@@ src/pair_draw_without_replacement_defines.svh @@
// Assertion macros for the pair draw block.
// Used by pair_draw_without_replacement.sv; needs clk and arst_n in scope.
`ifndef PAIR_DRAW_WITHOUT_REPLACEMENT_DEFINES_SVH
`define PAIR_DRAW_WITHOUT_REPLACEMENT_DEFINES_SVH

// Clocked property, off while reset is asserted.
`define PDWR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, off while reset is asserted.
`define PDWR_ASSERT_IMP(label, ante, cons, msg) \
	`PDWR_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ src/pdwr_pkg.sv @@
// Shared types and codes for the pair draw block.
// No dependencies.
`default_nettype none
package pdwr_pkg;
	localparam logic [1:0] OP_REBUILD = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_DRAW    = 2'd2;

	localparam logic [1:0] ST_VALID     = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_RETRY     = 2'd2;
	localparam logic [1:0] ST_CONTROL   = 2'd3;

	localparam logic [1:0] REG_KIND   = 2'd0;
	localparam logic [1:0] REG_FIRST  = 2'd1;
	localparam logic [1:0] REG_SECOND = 2'd2;

	localparam int RAND_W = 31;
	localparam int IDX_W  = 16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SIZE,
		S_CHECK,
		S_FILL,
		S_DIV,
		S_RD_P,
		S_RD_L,
		S_WR_P,
		S_WR_L,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

@@ src/pdwr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pdwr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ src/pair_draw_without_replacement.sv @@
// Pair draw without replacement: Fisher-Yates sampler over a table of index pairs.
//
// Input stream: s_tuser = operation (rebuild, restart, draw), s_tdata = random_a, random_b.
// Output stream: one word per input word; m_tuser = status, m_tdata = indices, moves_left.
// APB port: pair_kind at 0x0, size_first at 0x4, size_second at 0x8; write only when idle.
// One item at a time; s_tready is high in the idle state only.
// Restart and unused codes go straight from idle to the done state.
// A table draw runs the bit-serial remainder unit on random_a, then four steps,
// read, read, write, write, on the table RAM (one write port, one read port).
// A random-mode draw runs the remainder unit twice, once per index.
// A rebuild sizes the table and checks it against TABLE_DEPTH, then writes
// one table entry per cycle; it skips the writes when it picks random mode.
// The output register holds a finished word while the next item is taken in;
// if it is still full when the next result is ready, the block waits in its
// done state until the receiver takes the word. Reset puts the block in random
// mode with zero counts; the table contents are undefined until a rebuild.
`default_nettype none
`include "pair_draw_without_replacement_defines.svh"
module pair_draw_without_replacement #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // [30:0] random_a, [61:31] random_b, [63:62] zero
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // [15:0] first_index, [31:16] second_index,
	                                   // [32] moves_left, [39:33] zero
	output logic [1:0]       m_tuser   // [1:0] status
);
	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int DW   = (CW > 16) ? CW : 16;
	localparam int RW   = pdwr_pkg::RAND_W;
	localparam int XW   = pdwr_pkg::IDX_W;
	localparam int DCW  = $clog2(RW + 1);

	// configuration
	logic          kind_q;
	logic [XW-1:0] sf_q, ss_q;

	// block state
	logic          random_q;
	logic [CW-1:0] remaining_q, total_q;

	pdwr_pkg::state_t state_q, state_d;

	logic [RW-1:0] rb_q;
	logic [31:0]   prod_q;
	logic [CW-1:0] count_q, k_q;
	logic [XW-1:0] i_q, j_q;

	// remainder unit
	logic [RW-1:0]  dvd_q;
	logic [DW-1:0]  dvs_q, rem_q;
	logic [DCW-1:0] dcnt_q;
	logic           phase_q;
	logic [DW:0]    trial;
	logic [DW-1:0]  rem_next;

	// result and output registers
	logic [XW-1:0] res_first_q, res_second_q;
	logic [1:0]    res_status_q;
	logic [XW-1:0] out_first_q, out_second_q;
	logic [1:0]    out_status_q;
	logic          out_moves_q, m_valid_q;

	// table
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata, picked_q;

	logic          s_fire, out_free, div_last, fill_done;
	logic [31:0]   count32;
	logic [CW-1:0] last_idx;
	logic [XW-1:0] mod_val;

	assign pready   = 1'b1;
	assign s_tready = (state_q == pdwr_pkg::S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign div_last = (dcnt_q == DCW'(RW - 1));
	assign fill_done = (k_q == count_q);
	assign count32  = kind_q ? prod_q : {1'b0, prod_q[31:1]};
	assign last_idx = remaining_q - CW'(1);

	assign trial    = {rem_q, dvd_q[RW-1]};
	assign rem_next = (trial >= {1'b0, dvs_q}) ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
	// a zero divisor gives index zero
	assign mod_val  = (dvs_q == '0) ? '0 : rem_next[XW-1:0];

	// APB register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
			sf_q   <= XW'(2);
			ss_q   <= XW'(2);
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				pdwr_pkg::REG_KIND:   kind_q <= pwdata[0];
				pdwr_pkg::REG_FIRST:  sf_q   <= pwdata[XW-1:0];
				pdwr_pkg::REG_SECOND: ss_q   <= pwdata[XW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pdwr_pkg::REG_KIND:   prdata = {31'd0, kind_q};
			pdwr_pkg::REG_FIRST:  prdata = {16'd0, sf_q};
			pdwr_pkg::REG_SECOND: prdata = {16'd0, ss_q};
			default:              prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdwr_pkg::S_IDLE: begin
				if (s_fire) begin
					if (s_tuser == pdwr_pkg::OP_REBUILD) begin
						state_d = pdwr_pkg::S_SIZE;
					end else if (s_tuser == pdwr_pkg::OP_DRAW &&
							(random_q || remaining_q != '0)) begin
						state_d = pdwr_pkg::S_DIV;
					end else begin
						state_d = pdwr_pkg::S_DONE;
					end
				end
			end
			pdwr_pkg::S_SIZE:  state_d = pdwr_pkg::S_CHECK;
			pdwr_pkg::S_CHECK: begin
				if ({1'b0, count32} > 33'(TABLE_DEPTH)) begin
					state_d = pdwr_pkg::S_DONE;
				end else begin
					state_d = pdwr_pkg::S_FILL;
				end
			end
			pdwr_pkg::S_FILL: begin
				if (fill_done) begin
					state_d = pdwr_pkg::S_DONE;
				end
			end
			pdwr_pkg::S_DIV: begin
				if (div_last) begin
					if (!random_q) begin
						state_d = pdwr_pkg::S_RD_P;
					end else if (phase_q) begin
						state_d = pdwr_pkg::S_DONE;
					end
				end
			end
			pdwr_pkg::S_RD_P: state_d = pdwr_pkg::S_RD_L;
			pdwr_pkg::S_RD_L: state_d = pdwr_pkg::S_WR_P;
			pdwr_pkg::S_WR_P: state_d = pdwr_pkg::S_WR_L;
			pdwr_pkg::S_WR_L: state_d = pdwr_pkg::S_DONE;
			pdwr_pkg::S_DONE: begin
				if (out_free) begin
					state_d = pdwr_pkg::S_IDLE;
				end
			end
			default: state_d = pdwr_pkg::S_IDLE;
		endcase
	end

	// table port controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q[AW-1:0];
		ram_wdata = {i_q, j_q};
		ram_raddr = rem_q[AW-1:0];
		unique case (state_q)
			pdwr_pkg::S_FILL: ram_we = !fill_done;
			pdwr_pkg::S_RD_L: ram_raddr = last_idx[AW-1:0];
			pdwr_pkg::S_WR_P: begin
				ram_we    = 1'b1;
				ram_waddr = rem_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			pdwr_pkg::S_WR_L: begin
				ram_we    = 1'b1;
				ram_waddr = last_idx[AW-1:0];
				ram_wdata = picked_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdwr_pkg::S_IDLE;
			random_q    <= 1'b1;
			remaining_q <= '0;
			total_q     <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pdwr_pkg::S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				pdwr_pkg::S_IDLE: begin
					if (s_fire && s_tuser == pdwr_pkg::OP_RESTART) begin
						remaining_q <= total_q;
					end
				end
				pdwr_pkg::S_CHECK: begin
					if ({1'b0, count32} > 33'(TABLE_DEPTH)) begin
						random_q    <= 1'b1;
						remaining_q <= '0;
						total_q     <= '0;
					end else begin
						random_q    <= 1'b0;
						remaining_q <= '0;
						total_q     <= '0;
					end
				end
				pdwr_pkg::S_FILL: begin
					if (fill_done) begin
						remaining_q <= count_q;
						total_q     <= count_q;
					end
				end
				pdwr_pkg::S_WR_L: remaining_q <= last_idx;
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			pdwr_pkg::S_IDLE: begin
				rb_q         <= s_tdata[2*RW-1:RW];
				res_first_q  <= '0;
				res_second_q <= '0;
				res_status_q <= (s_tuser == pdwr_pkg::OP_DRAW) ?
					pdwr_pkg::ST_EXHAUSTED : pdwr_pkg::ST_CONTROL;
				dvd_q   <= s_tdata[RW-1:0];
				rem_q   <= '0;
				dcnt_q  <= '0;
				phase_q <= 1'b0;
				dvs_q   <= random_q ? DW'(sf_q) : DW'(remaining_q);
			end
			pdwr_pkg::S_SIZE: begin
				prod_q <= kind_q ? (32'(sf_q) * 32'(ss_q)) :
					(32'(sf_q) * 32'(sf_q - ((sf_q == '0) ? XW'(0) : XW'(1))));
			end
			pdwr_pkg::S_CHECK: begin
				count_q <= count32[CW-1:0];
				k_q     <= '0;
				i_q     <= '0;
				j_q     <= kind_q ? XW'(0) : XW'(1);
			end
			pdwr_pkg::S_FILL: begin
				if (!fill_done) begin
					k_q <= k_q + CW'(1);
					if (kind_q) begin
						if ({1'b0, j_q} + 17'd1 >= {1'b0, ss_q}) begin
							i_q <= i_q + XW'(1);
							j_q <= '0;
						end else begin
							j_q <= j_q + XW'(1);
						end
					end else if ({1'b0, j_q} + 17'd1 >= {1'b0, sf_q}) begin
						i_q <= i_q + XW'(1);
						j_q <= i_q + XW'(2);
					end else begin
						j_q <= j_q + XW'(1);
					end
				end
			end
			pdwr_pkg::S_DIV: begin
				if (!div_last) begin
					rem_q  <= rem_next;
					dvd_q  <= {dvd_q[RW-2:0], 1'b0};
					dcnt_q <= dcnt_q + DCW'(1);
				end else if (!random_q) begin
					rem_q <= rem_next;
				end else if (!phase_q) begin
					// first index done, run again for the second
					res_first_q <= mod_val;
					phase_q     <= 1'b1;
					rem_q       <= '0;
					dcnt_q      <= '0;
					dvd_q       <= rb_q;
					dvs_q       <= kind_q ? DW'(ss_q) : DW'(sf_q);
				end else if (!kind_q && mod_val == res_first_q) begin
					res_first_q  <= '0;
					res_second_q <= '0;
					res_status_q <= pdwr_pkg::ST_RETRY;
				end else begin
					res_second_q <= mod_val;
					res_status_q <= pdwr_pkg::ST_VALID;
				end
			end
			pdwr_pkg::S_RD_L: picked_q <= ram_rdata;
			pdwr_pkg::S_WR_L: begin
				res_first_q  <= picked_q[31:16];
				res_second_q <= picked_q[15:0];
				res_status_q <= pdwr_pkg::ST_VALID;
			end
			pdwr_pkg::S_DONE: begin
				if (out_free) begin
					out_first_q  <= res_first_q;
					out_second_q <= res_second_q;
					out_status_q <= res_status_q;
					out_moves_q  <= random_q || (remaining_q != '0);
				end
			end
			default: ;
		endcase
	end

	pdwr_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, out_moves_q, out_second_q, out_first_q};
	assign m_tuser  = out_status_q;

	`PDWR_ASSERT(a_remaining_le_total,
		remaining_q <= total_q || state_q == pdwr_pkg::S_CHECK,
		"remaining count above total")
	`PDWR_ASSERT_IMP(a_random_zero,
		random_q && state_q != pdwr_pkg::S_FILL,
		remaining_q == '0 && total_q == '0, "random mode with live counts")
	`PDWR_ASSERT_IMP(a_draw_decrements, state_q == pdwr_pkg::S_WR_L,
		##1 remaining_q == $past(remaining_q) - CW'(1), "draw did not drop count")
endmodule
`default_nettype wire

@@ tb/sv/tb_pair_draw_without_replacement.sv @@
// Self-checking bench for pair_draw_without_replacement: random and table draws
// are predicted by a scoreboard class and checked word by word on the output stream.
// Depends on pdwr_pkg and the block itself.
`default_nettype none
module tb_pair_draw_without_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DEPTH = 1024;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
		logic [1:0]  status;
		logic        moves_left;
	} pair_word_t;

	class pair_scoreboard;
		logic [31:0] pairs[DEPTH];
		int unsigned live;
		int unsigned total;
		bit          rnd_mode;
		bit          kind;
		int unsigned n_first;
		int unsigned n_second;
		pair_word_t  expected_q[$];
		int          errors;

		function new();
			live = 0;
			total = 0;
			rnd_mode = 1;
			kind = 0;
			n_first = 2;
			n_second = 2;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				pdwr_pkg::REG_KIND:   kind = val[0];
				pdwr_pkg::REG_FIRST:  n_first = val[15:0];
				pdwr_pkg::REG_SECOND: n_second = val[15:0];
				default: ;
			endcase
		endfunction

		function void rebuild_table();
			longint unsigned cnt;
			int unsigned k;
			int unsigned lo;
			int unsigned hi;
			if (kind == 0)
				cnt = (n_first == 0) ? 0 : longint'(n_first) * (n_first - 1) / 2;
			else
				cnt = longint'(n_first) * n_second;
			if (cnt > DEPTH) begin
				rnd_mode = 1;
				live = 0;
				total = 0;
				return;
			end
			rnd_mode = 0;
			k = 0;
			for (int unsigned i = 0; i < n_first; i++) begin
				lo = (kind == 0) ? i + 1 : 0;
				hi = (kind == 0) ? n_first : n_second;
				for (int unsigned j = lo; j < hi; j++) begin
					pairs[k] = {i[15:0], j[15:0]};
					k++;
				end
			end
			total = 32'(cnt);
			live = 32'(cnt);
		endfunction

		function void note_input(logic [1:0] op, logic [30:0] ra, logic [30:0] rb);
			pair_word_t w;
			int unsigned p;
			logic [31:0] picked;
			w = '0;
			w.status = pdwr_pkg::ST_CONTROL;
			case (op)
				pdwr_pkg::OP_REBUILD: rebuild_table();
				pdwr_pkg::OP_RESTART: live = total;
				pdwr_pkg::OP_DRAW: begin
					if (rnd_mode) begin
						w.first = (n_first == 0) ? 16'd0 : 16'(ra % n_first);
						if (kind == 0) begin
							w.second = (n_first == 0) ? 16'd0 : 16'(rb % n_first);
							if (w.first == w.second) begin
								w.first = 0;
								w.second = 0;
								w.status = pdwr_pkg::ST_RETRY;
							end else
								w.status = pdwr_pkg::ST_VALID;
						end else begin
							w.second = (n_second == 0) ? 16'd0 : 16'(rb % n_second);
							w.status = pdwr_pkg::ST_VALID;
						end
					end else if (live == 0) begin
						w.status = pdwr_pkg::ST_EXHAUSTED;
					end else begin
						// swap picked entry with last live one
						p = ra % live;
						picked = pairs[p];
						pairs[p] = pairs[live - 1];
						pairs[live - 1] = picked;
						live--;
						w.first = picked[31:16];
						w.second = picked[15:0];
						w.status = pdwr_pkg::ST_VALID;
					end
				end
				default: ;
			endcase
			w.moves_left = rnd_mode || live != 0;
			expected_q.push_back(w);
		endfunction

		function void check_result(pair_word_t got);
			pair_word_t exp_w;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, got);
				errors++;
				return;
			end
			exp_w = expected_q.pop_front();
			if (got.first !== exp_w.first)
				$display("%0t: first_index exp %h got %h", $realtime, exp_w.first, got.first);
			if (got.second !== exp_w.second)
				$display("%0t: second_index exp %h got %h", $realtime, exp_w.second, got.second);
			if (got.status !== exp_w.status)
				$display("%0t: status exp %h got %h", $realtime, exp_w.status, got.status);
			if (got.moves_left !== exp_w.moves_left)
				$display("%0t: moves_left exp %h got %h", $realtime, exp_w.moves_left,
					got.moves_left);
			if (got !== exp_w)
				errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	pair_scoreboard sb;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles;

	pair_draw_without_replacement #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// check output before noting input: a result never belongs to the word taken this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result({m_tdata[15:0], m_tdata[31:16], m_tuser, m_tdata[32]});
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser, s_tdata[30:0], s_tdata[61:31]);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[pair_draw_without_replacement] ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		sb.set_reg(idx, val);
	endtask

	// called at a clock edge; returns at the edge that takes the word
	task automatic send_word(logic [1:0] op, logic [30:0] ra, logic [30:0] rb);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {2'b00, rb, ra};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [30:0] rand_word();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		return 31'($urandom());
	endfunction

	task automatic run_phase(int idx, bit kind, int unsigned nf, int unsigned ns, int n);
		int unsigned r;
		case (idx % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 77; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 77; end
			default: begin idle_pct = 28; stall_pct = 28; end
		endcase
		drain();
		write_reg(pdwr_pkg::REG_KIND, 32'(kind));
		write_reg(pdwr_pkg::REG_FIRST, nf);
		write_reg(pdwr_pkg::REG_SECOND, ns);
		send_word(pdwr_pkg::OP_REBUILD, rand_word(), rand_word());
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 85)
				send_word(pdwr_pkg::OP_DRAW, rand_word(), rand_word());
			else if (r < 92)
				send_word(pdwr_pkg::OP_RESTART, rand_word(), rand_word());
			else if (r < 97)
				send_word(pdwr_pkg::OP_REBUILD, rand_word(), rand_word());
			else
				send_word(OP_UNUSED, rand_word(), rand_word());
		end
	endtask

	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset random mode, retry, control codes, one-entry table
		send_word(pdwr_pkg::OP_DRAW, 31'd1, 31'd0);
		send_word(pdwr_pkg::OP_DRAW, 31'd0, 31'd0);
		send_word(pdwr_pkg::OP_DRAW, '1, '1);
		send_word(OP_UNUSED, '1, '1);
		send_word(pdwr_pkg::OP_RESTART, 31'd0, 31'd0);
		send_word(pdwr_pkg::OP_REBUILD, 31'd0, 31'd0);
		send_word(pdwr_pkg::OP_DRAW, '1, 31'd0);
		send_word(pdwr_pkg::OP_DRAW, 31'd5, 31'd5);
		send_word(pdwr_pkg::OP_RESTART, 31'd0, 31'd0);
		send_word(pdwr_pkg::OP_DRAW, 31'd0, '1);
		send_word(OP_UNUSED, 31'd0, 31'd0);
		drain();
		// config change in random mode applies to draws without rebuild
		write_reg(pdwr_pkg::REG_KIND, 1);
		write_reg(pdwr_pkg::REG_FIRST, 32'hFFFF);
		write_reg(pdwr_pkg::REG_SECOND, 32'hFFFF);
		send_word(pdwr_pkg::OP_REBUILD, 31'd0, 31'd0);
		send_word(pdwr_pkg::OP_DRAW, '1, '1);
		send_word(pdwr_pkg::OP_DRAW, 31'd65535, 31'd65534);
		drain();
		write_reg(pdwr_pkg::REG_KIND, 0);
		send_word(pdwr_pkg::OP_DRAW, '1, 31'd3);
		send_word(pdwr_pkg::OP_DRAW, 31'd7, 31'd7);

		run_phase(0, 0, 5, 1, 110);
		run_phase(1, 1, 3, 4, 110);
		run_phase(2, 0, 1, 9, 60);
		run_phase(3, 1, 1, 1, 60);
		run_phase(4, 0, 45, 2, 100);      // 990 entries, largest kind 0 table
		run_phase(5, 1, 32, 32, 100);     // exactly full table
		run_phase(6, 0, 46, 1, 100);      // 1035 entries, over the table: random mode
		run_phase(7, 1, 1025, 1, 80);
		run_phase(8, 0, 65535, 3, 80);
		run_phase(9, 1, 1, 1024, 60);
		run_phase(10, 1, 65535, 65535, 60);
		run_phase(11, 0, 2, 65535, 40);

		drain();
		if (sb.errors == 0)
			$display("[pair_draw_without_replacement] OK");
		else
			$display("[pair_draw_without_replacement] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+src
src/pdwr_pkg.sv
src/pdwr_ram.sv
src/pair_draw_without_replacement.sv
tb/sv/tb_pair_draw_without_replacement.sv
